### rtl/sdrc_pkg.sv
// ---------------------------------------------------------------------------
// sdrc_pkg
// Shared codes, types and constants of the segment display RAM controller.
// ---------------------------------------------------------------------------
package sdrc_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_DATA_WRITE = 2'd0;
    localparam logic [1:0] OP_CMD_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;
    localparam logic [1:0] OP_REFRESH    = 2'd3;

    // command decode
    localparam logic [7:0] CMD_MASK      = 8'hE0;
    localparam logic [7:0] CMD_LOAD_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'hC0;

    // fixed byte returned by an odd read
    localparam logic [7:0] STATUS_BYTE   = 8'h10;

    // result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_DIGIT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } ctl_state_t;

    // control group toward a digit memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } mem_ctl_t;

endpackage

### rtl/sdrc_if.sv
// ---------------------------------------------------------------------------
// sdrc channel interfaces
// Request and response channels, valid/ready handshake with payload.
// ---------------------------------------------------------------------------
interface sdrc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] port_data;
    logic       read_select;
    logic [7:0] switch_bits;

    modport source (
        output valid, operation, port_data, read_select, switch_bits,
        input  ready
    );
    modport sink (
        input  valid, operation, port_data, read_select, switch_bits,
        output ready
    );
endinterface

interface sdrc_rsp_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] read_data;
    logic [4:0] digit_index;
    logic [3:0] old_digit;
    logic [3:0] new_digit;
    logic       last;

    modport source (
        output valid, kind, read_data, digit_index, old_digit, new_digit, last,
        input  ready
    );
    modport sink (
        input  valid, kind, read_data, digit_index, old_digit, new_digit, last,
        output ready
    );
endinterface

### rtl/sdrc_disp_mem.sv
// ---------------------------------------------------------------------------
// sdrc_disp_mem
// Display RAM: one row per word address, two digit nibbles per row.
// Row valid bits give reset and clear; invalid rows read zero.
// ---------------------------------------------------------------------------
module sdrc_disp_mem #(
    parameter int ROWS  = 16,
    parameter int ROW_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sdrc_pkg::mem_ctl_t ctl,
    input  logic [ROW_W-1:0]  wr_row,
    input  logic [7:0]        wr_data,
    input  logic [ROW_W-1:0]  rd_row,
    output logic [7:0]        rd_data
);
    import sdrc_pkg::*;

    logic [7:0]      mem [ROWS];
    logic [7:0]      q_reg;
    logic            q_valid_reg;
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        if (ctl.wr_en)
        begin
            valid_next[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                q_valid_reg <= valid_reg[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= mem[rd_row];
        end
    end

    assign rd_data = q_valid_reg ? q_reg : 8'h00;

endmodule

### rtl/sdrc_shown_mem.sv
// ---------------------------------------------------------------------------
// sdrc_shown_mem
// Copy of the digits as last shown, one nibble per digit.
// Entry valid bits give the zero reset; invalid entries read zero.
// ---------------------------------------------------------------------------
module sdrc_shown_mem #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sdrc_pkg::mem_ctl_t ctl,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [3:0]        wr_data,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [3:0]        rd_data
);
    import sdrc_pkg::*;

    logic [3:0]       mem [DEPTH];
    logic [3:0]       q_reg;
    logic             q_valid_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        if (ctl.wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                q_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= mem[rd_idx];
        end
    end

    assign rd_data = q_valid_reg ? q_reg : 4'h0;

endmodule

### rtl/segment_display_ram_controller.sv
// ---------------------------------------------------------------------------
// segment_display_ram_controller
// Display RAM section of a keyboard/display controller: data and command
// writes, switch/status reads, and a refresh that reports changed digits.
// ---------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   operation, port_data, read_select, switch_bits
//  rsp      out  kind, read_data, digit_index, old_digit, new_digit, last
//
//  Writes, commands and reads are taken in ST_IDLE. A refresh has a start,
//  a walk of one digit per cycle through the memories (a stall on rsp holds
//  it at a changed digit while a report is pending), and a final flush; each
//  digit memory has a single read port. Reset clears the digit memories
//  through per-entry valid bits at once; there is no clearing pass.
// ---------------------------------------------------------------------------
module segment_display_ram_controller #(
    parameter int DIGIT_COUNT = 32
) (
    input logic       clk,
    input logic       rst_n,
    sdrc_req_if.sink   req,
    sdrc_rsp_if.source rsp
);
    import sdrc_pkg::*;

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int ROWS  = (DIGIT_COUNT + 1) / 2;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    // control state
    ctl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       word_addr_reg, word_addr_next;
    logic             auto_inc_reg, auto_inc_next;
    logic             first_reg, first_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // pending digit report: held back until we know whether it is the last
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [3:0]       pend_old_reg, pend_old_next;
    logic [3:0]       pend_new_reg, pend_new_next;

    // output register
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_rdata_reg, out_rdata_next;
    logic [4:0]       out_idx_reg, out_idx_next;
    logic [3:0]       out_old_reg, out_old_next;
    logic [3:0]       out_new_reg, out_new_next;
    logic             out_last_reg, out_last_next;

    // memory ports
    mem_ctl_t         disp_ctl;
    logic [ROW_W-1:0] disp_wr_row;
    logic [ROW_W-1:0] disp_rd_row;
    logic [7:0]       disp_rd_data;
    mem_ctl_t         shown_ctl;
    logic [IDX_W-1:0] shown_rd_idx;
    logic [3:0]       shown_rd_data;

    logic             out_can_load;
    logic             accept;
    logic [3:0]       cur_new;
    logic             emit;
    logic             advance;
    logic [IDX_W-1:0] idx_inc;

    sdrc_disp_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_disp_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (disp_ctl),
        .wr_row  (disp_wr_row),
        .wr_data (req.port_data),
        .rd_row  (disp_rd_row),
        .rd_data (disp_rd_data)
    );

    sdrc_shown_mem #(
        .DEPTH (DIGIT_COUNT),
        .IDX_W (IDX_W)
    ) u_shown_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (shown_ctl),
        .wr_idx  (idx_reg),
        .wr_data (cur_new),
        .rd_idx  (shown_rd_idx),
        .rd_data (shown_rd_data)
    );

    // output register frees up when empty or being taken this cycle
    assign out_can_load = !out_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == ST_IDLE) && out_can_load;
    assign accept       = req.valid && req.ready;

    // digit under compare: low nibble for even cells, high for odd
    assign cur_new = idx_reg[0] ? disp_rd_data[7:4] : disp_rd_data[3:0];
    assign emit    = first_reg || (shown_rd_data != cur_new);
    // a report needs a free pending slot, or the pending one moves out
    assign advance = (state_reg == ST_WALK) &&
                     (!emit || !pend_valid_reg || out_can_load);
    assign idx_inc = idx_reg + 1'b1;

    assign disp_wr_row = ROW_W'(word_addr_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        word_addr_next  = word_addr_reg;
        auto_inc_next   = auto_inc_reg;
        first_next      = first_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_old_next   = pend_old_reg;
        pend_new_next   = pend_new_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_rdata_next  = out_rdata_reg;
        out_idx_next    = out_idx_reg;
        out_old_next    = out_old_reg;
        out_new_next    = out_new_reg;
        out_last_next   = out_last_reg;

        disp_ctl     = '0;
        shown_ctl    = '0;
        disp_rd_row  = ROW_W'(idx_inc >> 1);
        shown_rd_idx = idx_inc;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_DATA_WRITE:
                        begin
                            // rows past the digit count are not stored
                            if ({1'b0, word_addr_reg} < 5'(ROWS))
                            begin
                                disp_ctl.wr_en = 1'b1;
                            end
                            word_addr_next = word_addr_reg + {3'b000, auto_inc_reg};
                        end
                        OP_CMD_WRITE:
                        begin
                            if ((req.port_data & CMD_MASK) == CMD_LOAD_ADDR)
                            begin
                                word_addr_next = req.port_data[3:0];
                                auto_inc_next  = req.port_data[4];
                            end
                            else if ((req.port_data & CMD_MASK) == CMD_CLEAR)
                            begin
                                disp_ctl.clear = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_READ;
                            out_rdata_next = req.read_select ? STATUS_BYTE
                                                             : req.switch_bits;
                            out_idx_next   = 5'd0;
                            out_old_next   = 4'd0;
                            out_new_next   = 4'd0;
                            out_last_next  = 1'b1;
                        end
                        default:
                        begin
                            // refresh: fetch digit 0 from both memories
                            disp_ctl.rd_en  = 1'b1;
                            shown_ctl.rd_en = 1'b1;
                            disp_rd_row     = '0;
                            shown_rd_idx    = '0;
                            idx_next        = '0;
                            state_next      = ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    shown_ctl.wr_en = 1'b1;
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_DIGIT;
                            out_rdata_next = 8'h00;
                            out_idx_next   = 5'(pend_idx_reg);
                            out_old_next   = pend_old_reg;
                            out_new_next   = pend_new_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        pend_old_next   = shown_rd_data;
                        pend_new_next   = cur_new;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        first_next = 1'b0;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next        = idx_inc;
                        disp_ctl.rd_en  = 1'b1;
                        shown_ctl.rd_en = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DIGIT;
                    out_rdata_next  = 8'h00;
                    out_idx_next    = 5'(pend_idx_reg);
                    out_old_next    = pend_old_reg;
                    out_new_next    = pend_new_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            word_addr_reg  <= 4'd0;
            auto_inc_reg   <= 1'b0;
            first_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            word_addr_reg  <= word_addr_next;
            auto_inc_reg   <= auto_inc_next;
            first_reg      <= first_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        pend_old_reg  <= pend_old_next;
        pend_new_reg  <= pend_new_next;
        out_kind_reg  <= out_kind_next;
        out_rdata_reg <= out_rdata_next;
        out_idx_reg   <= out_idx_next;
        out_old_reg   <= out_old_next;
        out_new_reg   <= out_new_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.read_data   = out_rdata_reg;
    assign rsp.digit_index = out_idx_reg;
    assign rsp.old_digit   = out_old_reg;
    assign rsp.new_digit   = out_new_reg;
    assign rsp.last        = out_last_reg;

endmodule
